>>> hdl/cigar_window_interval_splitter_assert.svh
// assertion macros used by the checker of this block
`ifndef CIGAR_WINDOW_INTERVAL_SPLITTER_ASSERT_SVH
`define CIGAR_WINDOW_INTERVAL_SPLITTER_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define CWIS_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cwis check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define CWIS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cwis check failed");

`endif

>>> hdl/cwis_pkg.sv
`default_nettype none

package cwis_pkg;

    // widths
    localparam int POS_W     = 32;
    localparam int CUR_W     = POS_W + 1;
    localparam int RUN_W     = 14;
    localparam int WIDTH_W   = 16;
    localparam int KIND_W    = 2;
    localparam int IDX_W     = 2;
    localparam int MAX_OUT   = 64;
    localparam int CNT_W     = $clog2(MAX_OUT + 1);
    localparam int DIV_CNT_W = $clog2(POS_W);
    localparam int OUT_W     = 4 * POS_W;

    // action codes
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_OP    = 1'b1;

    // operation kinds
    localparam logic [KIND_W-1:0] KIND_MATCH = 2'd0;
    localparam logic [KIND_W-1:0] KIND_INS   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DEL   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_SKIP  = 2'd3;

    // register indexes
    localparam logic [IDX_W-1:0] REG_WINDOW_WIDTH = 2'd0;
    localparam logic [IDX_W-1:0] REG_QUERY_START  = 2'd1;
    localparam logic [IDX_W-1:0] REG_TARGET_START = 2'd2;
    localparam logic [IDX_W-1:0] REG_TARGET_STOP  = 2'd3;

    // register reset values
    localparam longint unsigned RST_WIDTH  = 500;
    localparam longint unsigned RST_QSTART = 0;
    localparam longint unsigned RST_TSTART = 0;
    localparam longint unsigned RST_TSTOP  = 1;

    // first window end of the walk that reset leaves
    localparam longint unsigned RST_FIRST_M = (RST_TSTART / RST_WIDTH + 1) * RST_WIDTH;
    localparam logic [POS_W-1:0] RST_WINDOW_END = (RST_FIRST_M < RST_TSTOP) ?
        POS_W'(RST_FIRST_M - 1) : POS_W'(RST_TSTOP - 1);

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic div_step;
        logic start_fin;
        logic step;
        logic adv;
        logic flush;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_start;
        logic is_walk;
        logic w_zero;
        logic div_done;
        logic hit;
        logic rem_zero;
        logic adv_stall;
        logic flush_stall;
    } dp_stat_t;

endpackage

`default_nettype wire

>>> hdl/cwis_ctrl.sv
`default_nettype none

module cwis_ctrl
    import cwis_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  dp_stat_t       stat,
    output ctrl_cmd_t      cmd
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_DIV   = 6'b000010,
        ST_FIN   = 6'b000100,
        ST_STEP  = 6'b001000,
        ST_ADV   = 6'b010000,
        ST_FLUSH = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (stat.is_start)
                    begin
                        state_next = stat.w_zero ? ST_FIN : ST_DIV;
                    end
                    else if (stat.is_walk)
                    begin
                        state_next = ST_STEP;
                    end
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_done)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                cmd.start_fin = 1'b1;
                state_next    = ST_IDLE;
            end
            ST_STEP:
            begin
                cmd.step = 1'b1;
                if (stat.hit)
                begin
                    state_next = ST_ADV;
                end
                else
                begin
                    // run used up: hand over the held interval as the last one
                    cmd.flush  = 1'b1;
                    state_next = stat.flush_stall ? ST_FLUSH : ST_IDLE;
                end
            end
            ST_ADV:
            begin
                if (!stat.adv_stall)
                begin
                    cmd.adv    = 1'b1;
                    state_next = stat.rem_zero ? ST_FLUSH : ST_STEP;
                end
            end
            ST_FLUSH:
            begin
                cmd.flush = 1'b1;
                if (!stat.flush_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> hdl/cwis_dp.sv
`default_nettype none

module cwis_dp
    import cwis_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    // configuration
    input  wire logic              cfg_we,
    input  wire logic [IDX_W-1:0]  cfg_index,
    input  wire logic [POS_W-1:0]  cfg_data,
    // input beat fields
    input  wire logic              in_action,
    input  wire logic [KIND_W-1:0] in_kind,
    input  wire logic [RUN_W-1:0]  in_run,
    // control
    input  ctrl_cmd_t              cmd,
    output dp_stat_t               stat,
    // result beat
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [OUT_W-1:0]       out_data,
    output logic                   out_last
);

    // configuration registers
    logic [WIDTH_W-1:0] win_width_reg;
    logic [POS_W-1:0]   query_start_reg;
    logic [POS_W-1:0]   target_start_reg;
    logic [POS_W-1:0]   target_stop_reg;

    // walk state
    logic [CUR_W-1:0]     qcur_reg,       qcur_next;
    logic [CUR_W-1:0]     tcur_reg,       tcur_next;
    logic [POS_W-1:0]     end_reg,        end_next;
    logic                 open_reg,       open_next;
    logic                 exh_reg,        exh_next;
    logic [KIND_W-1:0]    kind_reg,       kind_next;
    logic [RUN_W-1:0]     rem_reg,        rem_next;
    logic [CNT_W-1:0]     cnt_reg,        cnt_next;
    logic [WIDTH_W-1:0]   rdiv_reg,       rdiv_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg,    div_cnt_next;
    logic                 pend_valid_reg, pend_valid_next;
    logic                 out_valid_reg,  out_valid_next;

    // interval and result payload
    logic [POS_W-1:0] first_q_reg;
    logic [POS_W-1:0] first_t_reg;
    logic [POS_W-1:0] last_q_reg;
    logic [POS_W-1:0] last_t_reg;
    logic [POS_W-1:0] pend_qb_reg;
    logic [POS_W-1:0] pend_qe_reg;
    logic [POS_W-1:0] pend_tb_reg;
    logic [POS_W-1:0] pend_te_reg;
    logic [OUT_W-1:0] out_data_reg;
    logic             out_last_reg;

    logic [CUR_W-1:0]   end_gap;
    logic               hit;
    logic [RUN_W-1:0]   n;
    logic [CUR_W-1:0]   qcur_adv;
    logic [CUR_W-1:0]   tcur_adv;
    logic               is_match;
    logic [POS_W-1:0]   fin;
    logic [CUR_W-1:0]   cand;
    logic [POS_W-1:0]   adv_end;
    logic               emit;
    logic               out_free;
    logic               load_out;
    logic [WIDTH_W:0]   rdiv_shift;
    logic [WIDTH_W:0]   rdiv_sub;
    logic [CUR_W-1:0]   first_m;
    logic [POS_W-1:0]   start_end;
    logic               ts_bit;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_width_reg    <= WIDTH_W'(RST_WIDTH);
            query_start_reg  <= POS_W'(RST_QSTART);
            target_start_reg <= POS_W'(RST_TSTART);
            target_stop_reg  <= POS_W'(RST_TSTOP);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WINDOW_WIDTH: win_width_reg    <= cfg_data[WIDTH_W-1:0];
                REG_QUERY_START:  query_start_reg  <= cfg_data;
                REG_TARGET_START: target_start_reg <= cfg_data;
                REG_TARGET_STOP:  target_stop_reg  <= cfg_data;
                default:          win_width_reg    <= win_width_reg;
            endcase
        end
    end

    // distance to the pending window end, zero means a full wrap away
    assign end_gap  = {1'b0, end_reg} - tcur_reg;
    assign hit      = !exh_reg && (end_gap != '0) && (end_gap[CUR_W-1:RUN_W] == '0)
                      && (end_gap[RUN_W-1:0] <= rem_reg);
    assign n        = hit ? end_gap[RUN_W-1:0] : rem_reg;
    assign qcur_adv = qcur_reg + CUR_W'(n);
    assign tcur_adv = tcur_reg + CUR_W'(n);
    assign is_match = (kind_reg == KIND_MATCH);

    // next window end after a cut
    assign fin     = target_stop_reg - POS_W'(1);
    assign cand    = {1'b0, end_reg} + CUR_W'(1) + CUR_W'(win_width_reg);
    assign adv_end = ((win_width_reg != '0) && (cand < {1'b0, target_stop_reg})) ?
                     (end_reg + POS_W'(win_width_reg)) : fin;

    // remainder of target start by window width, one bit a cycle
    assign ts_bit     = target_start_reg[DIV_CNT_W'(POS_W - 1) - div_cnt_reg];
    assign rdiv_shift = {rdiv_reg, ts_bit};
    assign rdiv_sub   = (rdiv_shift >= {1'b0, win_width_reg}) ?
                        (rdiv_shift - {1'b0, win_width_reg}) : rdiv_shift;

    // first window end of a new walk
    assign first_m   = {1'b0, target_start_reg} - CUR_W'(rdiv_reg) + CUR_W'(win_width_reg);
    assign start_end = ((win_width_reg != '0) && (first_m < {1'b0, target_stop_reg})) ?
                       POS_W'(first_m - CUR_W'(1)) : fin;

    // result hand-over
    assign emit     = open_reg && (cnt_reg < CNT_W'(MAX_OUT));
    assign out_free = !out_valid_reg || out_ready;
    assign load_out = (cmd.adv && emit && pend_valid_reg)
                      || (cmd.flush && pend_valid_reg && out_free);

    // status to the controller
    always_comb
    begin
        stat.is_start    = (in_action == ACT_START);
        stat.is_walk     = (in_action == ACT_OP) && (in_run != '0)
                           && ((in_kind == KIND_MATCH) || (in_kind == KIND_DEL));
        stat.w_zero      = (win_width_reg == '0);
        stat.div_done    = (div_cnt_reg == DIV_CNT_W'(POS_W - 1));
        stat.hit         = hit;
        stat.rem_zero    = (rem_reg == '0);
        stat.adv_stall   = emit && pend_valid_reg && !out_free;
        stat.flush_stall = pend_valid_reg && !out_free;
    end

    // walk state next values
    always_comb
    begin
        qcur_next       = qcur_reg;
        tcur_next       = tcur_reg;
        end_next        = end_reg;
        open_next       = open_reg;
        exh_next        = exh_reg;
        kind_next       = kind_reg;
        rem_next        = rem_reg;
        cnt_next        = cnt_reg;
        rdiv_next       = rdiv_reg;
        div_cnt_next    = div_cnt_reg;
        pend_valid_next = pend_valid_reg;
        out_valid_next  = load_out || (out_valid_reg && !out_ready);

        if (cmd.accept)
        begin
            kind_next = in_kind;
            rem_next  = in_run;
            cnt_next  = '0;
            if (in_action == ACT_START)
            begin
                qcur_next    = {1'b0, query_start_reg} - CUR_W'(1);
                tcur_next    = {1'b0, target_start_reg} - CUR_W'(1);
                open_next    = 1'b0;
                exh_next     = 1'b0;
                rdiv_next    = '0;
                div_cnt_next = '0;
            end
            else if (in_kind == KIND_INS)
            begin
                qcur_next = qcur_reg + CUR_W'(in_run);
            end
        end

        if (cmd.div_step)
        begin
            rdiv_next    = rdiv_sub[WIDTH_W-1:0];
            div_cnt_next = div_cnt_reg + DIV_CNT_W'(1);
        end

        if (cmd.start_fin)
        begin
            end_next = start_end;
        end

        // advance to the next cut or to the end of the run
        if (cmd.step)
        begin
            tcur_next = tcur_adv;
            rem_next  = rem_reg - n;
            if (is_match)
            begin
                qcur_next = qcur_adv;
                open_next = 1'b1;
            end
        end

        // cut at the window end
        if (cmd.adv)
        begin
            open_next = 1'b0;
            if (emit)
            begin
                pend_valid_next = 1'b1;
                cnt_next        = cnt_reg + CNT_W'(1);
            end
            if (end_reg == fin)
            begin
                exh_next = 1'b1;
            end
            else
            begin
                end_next = adv_end;
            end
        end

        if (cmd.flush && pend_valid_reg && out_free)
        begin
            pend_valid_next = 1'b0;
        end
    end

    // walk state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qcur_reg       <= {1'b0, POS_W'(RST_QSTART)} - CUR_W'(1);
            tcur_reg       <= {1'b0, POS_W'(RST_TSTART)} - CUR_W'(1);
            end_reg        <= RST_WINDOW_END;
            open_reg       <= 1'b0;
            exh_reg        <= 1'b0;
            kind_reg       <= KIND_SKIP;
            rem_reg        <= '0;
            cnt_reg        <= '0;
            rdiv_reg       <= '0;
            div_cnt_reg    <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            qcur_reg       <= qcur_next;
            tcur_reg       <= tcur_next;
            end_reg        <= end_next;
            open_reg       <= open_next;
            exh_reg        <= exh_next;
            kind_reg       <= kind_next;
            rem_reg        <= rem_next;
            cnt_reg        <= cnt_next;
            rdiv_reg       <= rdiv_next;
            div_cnt_reg    <= div_cnt_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // matched span and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.step && is_match)
        begin
            if (!open_reg)
            begin
                first_q_reg <= qcur_reg[POS_W-1:0] + POS_W'(1);
                first_t_reg <= tcur_reg[POS_W-1:0] + POS_W'(1);
            end
            last_q_reg <= qcur_adv[POS_W-1:0];
            last_t_reg <= tcur_adv[POS_W-1:0];
        end
        if (cmd.adv && emit)
        begin
            pend_qb_reg <= first_q_reg;
            pend_qe_reg <= last_q_reg + POS_W'(1);
            pend_tb_reg <= first_t_reg;
            pend_te_reg <= last_t_reg + POS_W'(1);
        end
        if (load_out)
        begin
            out_data_reg <= {pend_te_reg, pend_tb_reg, pend_qe_reg, pend_qb_reg};
            out_last_reg <= cmd.flush;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_last  = out_last_reg;

endmodule

`default_nettype wire

>>> hdl/cigar_window_interval_splitter.sv
`default_nettype none

// Splits an alignment, fed as one CIGAR operation per input beat, into matched
// query/target spans cut at target window ends (multiples of window_width
// minus one inside the target range, then target_stop minus one). A start beat
// (tuser action bit low) reloads the walk from the registers and keeps the
// input closed while the first window end is found: it needs target_start
// modulo window_width, which a one-bit-a-cycle remainder unit works out (not
// run when window_width is zero). Insertion, ignored and zero-length beats
// leave the controller idle. A match or deletion beat steps straight to each
// window end the run reaches and cuts the span there, until the run is used
// up. Each beat's spans go out in order; the last one of a beat carries tlast.
// At most 64 spans leave per beat. A pending register and an output register
// decouple the sides; the block only waits when a span is ready to move on
// while the one in the output register is still not taken.
module cigar_window_interval_splitter
    import cwis_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    // configuration write port
    input  wire logic              cfg_we,
    input  wire logic [IDX_W-1:0]  cfg_index,
    input  wire logic [POS_W-1:0]  cfg_data,
    // operation stream
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire logic [15:0]       s_axis_tdata,   // run_length[13:0], zero pad[15:14]
    input  wire logic [2:0]        s_axis_tuser,   // action[0], op_kind[2:1]
    // span stream
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output logic [OUT_W-1:0]       m_axis_tdata,   // query_begin, query_end,
                                                   // target_begin, target_end
    output logic                   m_axis_tlast    // last_of_run
);

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    // sequencer
    cwis_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // cursors, window ends and span registers
    cwis_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_action (s_axis_tuser[0]),
        .in_kind   (s_axis_tuser[2:1]),
        .in_run    (s_axis_tdata[RUN_W-1:0]),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

endmodule

`default_nettype wire

>>> hdl/cwis_checker.sv
`default_nettype none

`include "cigar_window_interval_splitter_assert.svh"

module cwis_checker
    import cwis_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_axis_tvalid,
    input  wire logic              s_axis_tready,
    input  wire logic [2:0]        s_axis_tuser,
    input  wire logic              m_axis_tvalid,
    input  wire logic              m_axis_tready,
    input  wire logic [OUT_W-1:0]  m_axis_tdata,
    input  wire logic              m_axis_tlast
);

    logic start_beat;
    logic ins_beat;
    logic out_stall;

    // beats that reload the walk or only move the query cursor
    assign start_beat = s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == ACT_START);
    assign ins_beat   = s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == ACT_OP)
                        && (s_axis_tuser[2:1] == KIND_INS);

    // span beat offered but not taken
    assign out_stall  = m_axis_tvalid && !m_axis_tready;

    // a stalled span beat stays offered
    `CWIS_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid)

    // a stalled span beat keeps its payload
    `CWIS_ASSERT_NEXT(a_out_stable, out_stall, $stable(m_axis_tdata) && $stable(m_axis_tlast))

    // a start beat keeps the input closed while the first window end is found
    `CWIS_ASSERT_NEXT(a_start_busy, start_beat, !s_axis_tready)

    // an insertion finishes in its own cycle
    `CWIS_ASSERT_NEXT(a_ins_single, ins_beat, s_axis_tready)

endmodule

bind cigar_window_interval_splitter cwis_checker u_cwis_checker (.*);

`default_nettype wire
